// ===== hw/rtl/atrp_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Tilt angle package
// Widths, fixed-point constants and the arctangent table shared by the
// roll/pitch pipeline.
// ----------------------------------------------------------------------------
package atrp_pkg;

    localparam int ATRP_ANGLE_ITERATIONS = 16;
    localparam int TABLE_LEN             = 24;

    localparam int SAMPLE_W      = 16;
    localparam int OPERAND_SHIFT = 16;
    localparam int ANGLE_FRAC    = 20;

    // Rotation datapath: 16-bit operands shifted up by 16, grown by two
    // CORDIC gains and the diagonal.
    localparam int CORDIC_W = 38;
    // Angle accumulator in units of 2^-20 degree, covers -512 up to just under +512 degrees.
    localparam int ANGLE_W  = 30;

    localparam int GAIN_W = 31;
    localparam logic [GAIN_W-1:0] GAIN_Q30 = 31'd1768195363;
    localparam int NX_SHIFT = 30 - OPERAND_SHIFT;
    localparam int PROD_W   = (SAMPLE_W + 1) + (GAIN_W + 1);

    localparam int ROLL_W  = 16;
    localparam int PITCH_W = 15;

    // |angle| * 100 and the rounded quotient.
    localparam int MAG_W = 37;
    localparam int Q_W   = MAG_W - ANGLE_FRAC;

    typedef logic signed [CORDIC_W-1:0] t_cordic;
    typedef logic signed [ANGLE_W-1:0]  t_angle;
    typedef logic [MAG_W-1:0]           t_mag;
    typedef logic [Q_W-1:0]             t_quot;

    localparam t_angle HALF_TURN    = t_angle'(180 * (2 ** ANGLE_FRAC));
    localparam t_angle QUARTER_TURN = t_angle'(90 * (2 ** ANGLE_FRAC));
    localparam t_mag   CENTI_SCALE  = t_mag'(100);
    localparam t_mag   ROUND_HALF   = t_mag'(2 ** (ANGLE_FRAC - 1));
    localparam t_quot  ROLL_LIMIT   = t_quot'(18000);
    localparam t_quot  PITCH_LIMIT  = t_quot'(9000);

    // atan(2^-i) in units of 2^-20 degree, rounded to nearest.
    localparam t_angle ATAN_TABLE [TABLE_LEN] = '{
        30'sd47185920, 30'sd27855475, 30'sd14718068, 30'sd7471121,
        30'sd3750058,  30'sd1876857,  30'sd938658,   30'sd469357,
        30'sd234682,   30'sd117342,   30'sd58671,    30'sd29335,
        30'sd14668,    30'sd7334,     30'sd3667,     30'sd1833,
        30'sd917,      30'sd458,      30'sd229,      30'sd115,
        30'sd57,       30'sd29,       30'sd14,       30'sd7
    };

    // One vector in flight through the rotation stages.
    typedef struct packed {
        t_cordic a;
        t_cordic b;
        t_angle  ang;
    } t_vec;

    // Per-item data that rides alongside the rotations.
    typedef struct packed {
        t_cordic nx;
        t_angle  roll_ang;
        logic    yz_zero;
        logic    x_zero;
        logic    x_neg;
    } t_side;

endpackage
`default_nettype wire

// ===== hw/rtl/atrp_ifs.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Tilt angle channels
// Valid/ready channels for the accelerometer sample and the angle result.
// ----------------------------------------------------------------------------
interface atrp_sample_if import atrp_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] accel_x;
    logic signed [SAMPLE_W-1:0] accel_y;
    logic signed [SAMPLE_W-1:0] accel_z;

    modport source (output valid, accel_x, accel_y, accel_z, input ready);
    modport sink   (input valid, accel_x, accel_y, accel_z, output ready);
endinterface

interface atrp_angle_if import atrp_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [ROLL_W-1:0]  roll_centideg;
    logic signed [PITCH_W-1:0] pitch_centideg;

    modport source (output valid, roll_centideg, pitch_centideg, input ready);
    modport sink   (input valid, roll_centideg, pitch_centideg, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/atrp_cordic_stage.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// CORDIC vectoring stage
// One registered micro-rotation that drives b toward zero and accumulates
// the angle turned.
// ----------------------------------------------------------------------------
module atrp_cordic_stage import atrp_pkg::*; #(
    parameter int STAGE_IDX = 0
) (
    input  wire  i_clk,
    input  wire  i_en,
    input  t_vec i_vec,
    output t_vec o_vec
);

    localparam t_angle STEP_ANGLE = ATAN_TABLE[STAGE_IDX];

    t_vec    r_vec;
    t_vec    n_vec;
    t_cordic w_da;
    t_cordic w_db;

    // Arithmetic shifts floor, matching the fixed-point definition.
    assign w_da = i_vec.b >>> STAGE_IDX;
    assign w_db = i_vec.a >>> STAGE_IDX;

    always_comb begin
        if (i_vec.b > 0) begin
            n_vec.a   = i_vec.a + w_da;
            n_vec.b   = i_vec.b - w_db;
            n_vec.ang = i_vec.ang + STEP_ANGLE;
        end else begin
            n_vec.a   = i_vec.a - w_da;
            n_vec.b   = i_vec.b + w_db;
            n_vec.ang = i_vec.ang - STEP_ANGLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_vec <= n_vec;
        end
    end

    assign o_vec = r_vec;

endmodule
`default_nettype wire

// ===== hw/rtl/accel_tilt_roll_pitch_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Accelerometer tilt angle unit
// Roll and pitch in hundredths of a degree from one raw three-axis sample.
// ----------------------------------------------------------------------------
// A fully pipelined unit: it takes one sample per clock while the output is
// not stalled and returns one roll/pitch item per sample, in order. The
// pipeline holds two chains of CORDIC micro-rotation stages, one for roll
// and one for pitch, plus an input stage, a scaling stage and the output
// register. A stall on the output freezes the whole pipeline, so nothing is
// dropped or repeated. Roll is -atan2(y, z) in -17999..18000; pitch is
// atan2(-x, |(y, z)|) in -9000..9000. An all-zero sample gives zero for
// both angles.
module accel_tilt_roll_pitch_unit import atrp_pkg::*; #(
    parameter int ANGLE_ITERATIONS = ATRP_ANGLE_ITERATIONS
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    atrp_sample_if.sink  i_sample,
    atrp_angle_if.source o_angle
);

    localparam int NUM_ROT   = (ANGLE_ITERATIONS < TABLE_LEN) ? ANGLE_ITERATIONS : TABLE_LEN;
    localparam int NUM_STAGE = 2 * NUM_ROT;

    logic w_adv;
    logic r_out_vld;

    // ---------------------------------------------------------------- input
    logic signed [SAMPLE_W:0] w_negx;
    logic signed [PROD_W-1:0] w_prod;
    t_cordic                  w_za;
    t_cordic                  w_yb;
    t_vec                     n_vec0;
    t_side                    n_side0;

    t_vec  r_vec0;
    t_side r_side [0:NUM_STAGE];
    logic  r_vld  [0:NUM_STAGE];
    t_vec  w_vec  [0:NUM_STAGE];
    t_vec  w_pin;

    assign w_adv          = !r_out_vld || o_angle.ready;
    assign i_sample.ready = w_adv;

    assign w_negx = -{i_sample.accel_x[SAMPLE_W-1], i_sample.accel_x};
    assign w_prod = w_negx * $signed({1'b0, GAIN_Q30});
    assign w_za   = {{(CORDIC_W-SAMPLE_W-OPERAND_SHIFT){i_sample.accel_z[SAMPLE_W-1]}},
                     i_sample.accel_z, {OPERAND_SHIFT{1'b0}}};
    assign w_yb   = {{(CORDIC_W-SAMPLE_W-OPERAND_SHIFT){i_sample.accel_y[SAMPLE_W-1]}},
                     i_sample.accel_y, {OPERAND_SHIFT{1'b0}}};

    always_comb begin
        // A vector in the left half plane is first turned by a half turn.
        if (i_sample.accel_z < 0) begin
            n_vec0.a   = -w_za;
            n_vec0.b   = -w_yb;
            n_vec0.ang = (i_sample.accel_y >= 0) ? HALF_TURN : -HALF_TURN;
        end else begin
            n_vec0.a   = w_za;
            n_vec0.b   = w_yb;
            n_vec0.ang = '0;
        end
        n_side0.nx       = t_cordic'(w_prod >>> NX_SHIFT);
        n_side0.roll_ang = '0;
        n_side0.yz_zero  = (i_sample.accel_y == 0) && (i_sample.accel_z == 0);
        n_side0.x_zero   = (i_sample.accel_x == 0);
        n_side0.x_neg    = i_sample.accel_x[SAMPLE_W-1];
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_vec0    <= n_vec0;
            r_side[0] <= n_side0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (w_adv) begin
            r_vld[0] <= i_sample.valid;
        end
    end

    assign w_vec[0] = r_vec0;

    // The gain-scaled (y, z) magnitude from the roll pass meets -x, which
    // carries the same gain, so the pitch pass needs no gain correction.
    assign w_pin.a   = w_vec[NUM_ROT].a;
    assign w_pin.b   = r_side[NUM_ROT].nx;
    assign w_pin.ang = '0;

    // ------------------------------------------------------- rotation stages
    for (genvar k = 0; k < NUM_STAGE; k++) begin : g_stage
        t_side w_side;

        if (k < NUM_ROT) begin : g_roll
            atrp_cordic_stage #(.STAGE_IDX(k)) u_rot (
                .i_clk (i_clk),
                .i_en  (w_adv),
                .i_vec (w_vec[k]),
                .o_vec (w_vec[k+1])
            );
        end else if (k == NUM_ROT) begin : g_pitch_first
            atrp_cordic_stage #(.STAGE_IDX(0)) u_rot (
                .i_clk (i_clk),
                .i_en  (w_adv),
                .i_vec (w_pin),
                .o_vec (w_vec[k+1])
            );
        end else begin : g_pitch
            atrp_cordic_stage #(.STAGE_IDX(k - NUM_ROT)) u_rot (
                .i_clk (i_clk),
                .i_en  (w_adv),
                .i_vec (w_vec[k]),
                .o_vec (w_vec[k+1])
            );
        end

        always_comb begin
            w_side = r_side[k];
            if (k == NUM_ROT) begin
                w_side.roll_ang = w_vec[NUM_ROT].ang;
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_side[k+1] <= w_side;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k+1] <= 1'b0;
            end else if (w_adv) begin
                r_vld[k+1] <= r_vld[k];
            end
        end
    end

    // -------------------------------------------------------------- scaling
    t_angle w_roll_ang;
    t_angle w_pitch_ang;
    t_angle w_pitch_clamp;
    t_angle w_roll_abs;
    t_angle w_pitch_abs;

    logic  r_c1_vld;
    t_mag  r_roll_m;
    t_mag  r_pitch_m;
    logic  r_roll_pos;
    logic  r_pitch_neg;
    logic  r_yz_zero;
    logic  r_x_zero;
    logic  r_x_neg;

    assign w_roll_ang  = r_side[NUM_STAGE].roll_ang;
    assign w_pitch_ang = w_vec[NUM_STAGE].ang;

    always_comb begin
        if (w_pitch_ang > QUARTER_TURN) begin
            w_pitch_clamp = QUARTER_TURN;
        end else if (w_pitch_ang < -QUARTER_TURN) begin
            w_pitch_clamp = -QUARTER_TURN;
        end else begin
            w_pitch_clamp = w_pitch_ang;
        end
        w_roll_abs  = (w_roll_ang < 0) ? -w_roll_ang : w_roll_ang;
        w_pitch_abs = (w_pitch_clamp < 0) ? -w_pitch_clamp : w_pitch_clamp;
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_roll_m    <= t_mag'(unsigned'(w_roll_abs)) * CENTI_SCALE;
            r_pitch_m   <= t_mag'(unsigned'(w_pitch_abs)) * CENTI_SCALE;
            r_roll_pos  <= (w_roll_ang > 0);
            r_pitch_neg <= (w_pitch_clamp < 0);
            r_yz_zero   <= r_side[NUM_STAGE].yz_zero;
            r_x_zero    <= r_side[NUM_STAGE].x_zero;
            r_x_neg     <= r_side[NUM_STAGE].x_neg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c1_vld <= 1'b0;
        end else if (w_adv) begin
            r_c1_vld <= r_vld[NUM_STAGE];
        end
    end

    // --------------------------------------------------------------- output
    t_mag                      w_roll_rnd;
    t_mag                      w_pitch_rnd;
    t_quot                     w_roll_q;
    t_quot                     w_pitch_q;
    logic signed [ROLL_W-1:0]  w_roll_mag;
    logic signed [PITCH_W-1:0] w_pitch_mag;
    logic signed [ROLL_W-1:0]  n_roll;
    logic signed [PITCH_W-1:0] n_pitch;

    logic signed [ROLL_W-1:0]  r_roll;
    logic signed [PITCH_W-1:0] r_pitch;

    always_comb begin
        w_roll_rnd  = r_roll_m + ROUND_HALF;
        w_pitch_rnd = r_pitch_m + ROUND_HALF;
        w_roll_q    = w_roll_rnd[MAG_W-1:ANGLE_FRAC];
        w_pitch_q   = w_pitch_rnd[MAG_W-1:ANGLE_FRAC];
        w_roll_mag  = (w_roll_q > ROLL_LIMIT) ? ROLL_W'(ROLL_LIMIT) : w_roll_q[ROLL_W-1:0];
        w_pitch_mag = (w_pitch_q > PITCH_LIMIT) ? PITCH_W'(PITCH_LIMIT)
                                                 : w_pitch_q[PITCH_W-1:0];

        if (r_yz_zero) begin
            n_roll = '0;
            if (r_x_zero) begin
                n_pitch = '0;
            end else if (r_x_neg) begin
                n_pitch = PITCH_W'(PITCH_LIMIT);
            end else begin
                n_pitch = -PITCH_W'(PITCH_LIMIT);
            end
        end else begin
            // Roll is the negated angle; a negative half turn reads as +18000.
            if (r_roll_pos && (w_roll_mag != ROLL_W'(ROLL_LIMIT))) begin
                n_roll = -w_roll_mag;
            end else begin
                n_roll = w_roll_mag;
            end
            n_pitch = r_pitch_neg ? -w_pitch_mag : w_pitch_mag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_roll  <= n_roll;
            r_pitch <= n_pitch;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_out_vld <= r_c1_vld;
        end
    end

    assign o_angle.valid          = r_out_vld;
    assign o_angle.roll_centideg  = r_roll;
    assign o_angle.pitch_centideg = r_pitch;

endmodule
`default_nettype wire

// ===== bench/testbench.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Tilt angle unit testbench
// Drives raw accelerometer samples into the roll/pitch pipeline and checks
// every angle item against a fixed-point CORDIC predictor or a hand-typed
// expectation. A short directed table comes first, then random samples
// with random idling on both sides, one long output stall and a drain pause.
// ----------------------------------------------------------------------------
module testbench import atrp_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ROTATIONS   = (ATRP_ANGLE_ITERATIONS < TABLE_LEN) ?
                                 ATRP_ANGLE_ITERATIONS : TABLE_LEN;
    localparam int LATENCY     = 2 * ROTATIONS + 3;
    localparam int RANDOM_ITEMS = 1250;
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 200;

    typedef struct packed {
        logic signed [ROLL_W-1:0]  roll;
        logic signed [PITCH_W-1:0] pitch;
    } t_tilt;

    // Directed sample with an optional hand-typed expectation.
    typedef struct packed {
        int x;
        int y;
        int z;
        bit typed;
        int roll;
        int pitch;
    } t_row;

    localparam int N_DIRECTED = 22;
    localparam t_row DIRECTED [N_DIRECTED] = '{
        '{0, 0, 0, 1'b1, 0, 0},
        '{1, 0, 0, 1'b1, 0, -9000},
        '{-1, 0, 0, 1'b1, 0, 9000},
        '{32767, 0, 0, 1'b1, 0, -9000},
        '{-32768, 0, 0, 1'b1, 0, 9000},
        '{0, 0, 32767, 1'b0, 0, 0},
        '{0, 0, -32768, 1'b0, 0, 0},
        '{0, 32767, 0, 1'b0, 0, 0},
        '{0, -32768, 0, 1'b0, 0, 0},
        '{0, 0, -1, 1'b0, 0, 0},
        '{0, -1, -32768, 1'b0, 0, 0},
        '{0, 1, -32768, 1'b0, 0, 0},
        '{32767, 32767, 32767, 1'b0, 0, 0},
        '{-32768, -32768, -32768, 1'b0, 0, 0},
        '{-32768, 32767, -32768, 1'b0, 0, 0},
        '{32767, -32768, 1, 1'b0, 0, 0},
        '{1, 1, 1, 1'b0, 0, 0},
        '{-1, -1, -1, 1'b0, 0, 0},
        '{-32768, 1, 0, 1'b0, 0, 0},
        '{32767, 0, 1, 1'b0, 0, 0},
        '{100, -100, -100, 1'b0, 0, 0},
        '{-12345, 23456, -21845, 1'b0, 0, 0}
    };

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    int   cycle_count = 0;
    int   mismatch_count = 0;
    bit   steady = 1'b0;
    bit   hold_off_req = 1'b0;
    int   hold_left = 0;
    t_tilt pending_angles [$];

    atrp_sample_if sample_ch ();
    atrp_angle_if  angle_ch ();

    accel_tilt_roll_pitch_unit uut (
        .i_clk    (clk),
        .i_rst_n  (rst_n),
        .i_sample (sample_ch),
        .o_angle  (angle_ch)
    );

    always #4 clk = ~clk;

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Vectoring micro-rotations: drives b toward zero, returns the angle in
    // 2^-20 degree and leaves the gain-scaled magnitude in mag.
    function automatic longint cordic_vector(input longint a0, input longint b0,
                                             output longint mag);
        longint a, b, ang, da, db;
        a   = a0;
        b   = b0;
        ang = 0;
        for (int i = 0; i < ROTATIONS; i++) begin
            da = b >>> i;
            db = a >>> i;
            if (b > 0) begin
                a   = a + da;
                b   = b - db;
                ang = ang + longint'(ATAN_TABLE[i]);
            end else begin
                a   = a - da;
                b   = b + db;
                ang = ang - longint'(ATAN_TABLE[i]);
            end
        end
        mag = a;
        return ang;
    endfunction

    function automatic longint centideg_round(input longint units);
        longint m, q;
        m = ((units < 0) ? -units : units) * 100;
        q = (m + (longint'(1) << (ANGLE_FRAC - 1))) >>> ANGLE_FRAC;
        return (units < 0) ? -q : q;
    endfunction

    function automatic t_tilt tilt_angles(input logic signed [SAMPLE_W-1:0] ax,
                                          input logic signed [SAMPLE_W-1:0] ay,
                                          input logic signed [SAMPLE_W-1:0] az);
        longint x, y, z, a, b, base, ang, mag, nx, pa, unused, roll, pitch;
        t_tilt  res;
        x = longint'(ax);
        y = longint'(ay);
        z = longint'(az);
        if (y == 0 && z == 0) begin
            roll  = 0;
            pitch = (x == 0) ? 0 : ((x < 0) ? 9000 : -9000);
        end else begin
            a    = z <<< OPERAND_SHIFT;
            b    = y <<< OPERAND_SHIFT;
            base = 0;
            // A vector in the left half plane is turned by a half turn first.
            if (z < 0) begin
                a    = -a;
                b    = -b;
                base = (y >= 0) ? (longint'(180) <<< ANGLE_FRAC)
                                : -(longint'(180) <<< ANGLE_FRAC);
            end
            ang  = base + cordic_vector(a, b, mag);
            roll = centideg_round(-ang);
            if (roll < -18000) roll = -18000;
            if (roll > 18000) roll = 18000;
            if (roll == -18000) roll = 18000;
            nx = ((-x) * longint'(GAIN_Q30)) >>> NX_SHIFT;
            pa = cordic_vector(mag, nx, unused);
            if (pa > (longint'(90) <<< ANGLE_FRAC)) pa = longint'(90) <<< ANGLE_FRAC;
            if (pa < -(longint'(90) <<< ANGLE_FRAC)) pa = -(longint'(90) <<< ANGLE_FRAC);
            pitch = centideg_round(pa);
            if (pitch > 9000) pitch = 9000;
            if (pitch < -9000) pitch = -9000;
        end
        res.roll  = roll[ROLL_W-1:0];
        res.pitch = pitch[PITCH_W-1:0];
        return res;
    endfunction

    // Called just after a falling edge; returns just after a later one, once the sample is taken.
    task automatic send_sample(input int x, input int y, input int z,
                               input bit typed, input t_tilt typed_angles);
        while (!steady && $urandom_range(99) < 14) begin
            sample_ch.valid = 1'b0;
            @(negedge clk);
        end
        sample_ch.valid   = 1'b1;
        sample_ch.accel_x = x[SAMPLE_W-1:0];
        sample_ch.accel_y = y[SAMPLE_W-1:0];
        sample_ch.accel_z = z[SAMPLE_W-1:0];
        @(posedge clk);
        while (!sample_ch.ready) @(posedge clk);
        if (typed)
            pending_angles.push_back(typed_angles);
        else
            pending_angles.push_back(tilt_angles(x[SAMPLE_W-1:0], y[SAMPLE_W-1:0],
                                                 z[SAMPLE_W-1:0]));
        @(negedge clk);
    endtask

    task automatic drain_angles();
        sample_ch.valid = 1'b0;
        wait (pending_angles.size() == 0);
        @(negedge clk);
    endtask

    function automatic int pick_axis(input int mode);
        int edge_vals [7] = '{-32768, -32767, -1, 0, 1, 32766, 32767};
        case (mode)
            0: return $urandom_range(65535) - 32768;
            1: return $urandom_range(128) - 64;
            2: return edge_vals[$urandom_range(6)];
            default: return 0;
        endcase
    endfunction

    // Receiver side: random ready with one long hold-off on request.
    initial begin
        angle_ch.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (!rst_n) begin
                angle_ch.ready = 1'b0;
            end else if (hold_left > 0) begin
                angle_ch.ready = 1'b0;
                hold_left--;
            end else if (hold_off_req) begin
                hold_off_req   = 1'b0;
                hold_left      = HOLD_CYCLES;
                angle_ch.ready = 1'b0;
            end else begin
                angle_ch.ready = steady || ($urandom_range(99) >= 14);
            end
        end
    end

    always @(posedge clk) begin : check_angles
        t_tilt want;
        if (rst_n && angle_ch.valid && angle_ch.ready) begin
            if (pending_angles.size() == 0) begin
                $display("%0t: unexpected angle item roll %0d pitch %0d", $time,
                         angle_ch.roll_centideg, angle_ch.pitch_centideg);
                mismatch_count++;
            end else begin
                want = pending_angles.pop_front();
                if (angle_ch.roll_centideg !== want.roll) begin
                    $display("%0t: roll expected %0d got %0d", $time,
                             want.roll, angle_ch.roll_centideg);
                    mismatch_count++;
                end
                if (angle_ch.pitch_centideg !== want.pitch) begin
                    $display("%0t: pitch expected %0d got %0d", $time,
                             want.pitch, angle_ch.pitch_centideg);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        int    x, y, z, mode, big;
        t_tilt typed_angles;
        sample_ch.valid   = 1'b0;
        sample_ch.accel_x = '0;
        sample_ch.accel_y = '0;
        sample_ch.accel_z = '0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        for (int r = 0; r < N_DIRECTED; r++) begin
            typed_angles.roll  = DIRECTED[r].roll[ROLL_W-1:0];
            typed_angles.pitch = DIRECTED[r].pitch[PITCH_W-1:0];
            send_sample(DIRECTED[r].x, DIRECTED[r].y, DIRECTED[r].z,
                        DIRECTED[r].typed, typed_angles);
        end
        drain_angles();

        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            if (k == 150) hold_off_req = 1'b1;
            if (k == 450) steady = 1'b1;
            if (k == 750) steady = 1'b0;
            if (k == 1000) drain_angles();
            mode = $urandom_range(99);
            if (mode < 40) begin
                x = pick_axis(0); y = pick_axis(0); z = pick_axis(0);
            end else if (mode < 60) begin
                x = pick_axis(1); y = pick_axis(1); z = pick_axis(1);
            end else if (mode < 72) begin
                // Any axis may be zero by chance, the rest full range.
                x = ($urandom_range(2) == 0) ? 0 : pick_axis(0);
                y = ($urandom_range(1) == 0) ? 0 : pick_axis(0);
                z = ($urandom_range(1) == 0) ? 0 : pick_axis(0);
            end else if (mode < 88) begin
                // Small y with z mostly negative, so roll sits around the
                // half-turn wrap.
                big = $urandom_range(32767) + 1;
                x = pick_axis($urandom_range(1));
                y = pick_axis(1);
                z = ($urandom_range(3) == 0) ? big - 1 : -big;
            end else begin
                x = pick_axis(2); y = pick_axis(2); z = pick_axis(2);
            end
            send_sample(x, y, z, 1'b0, typed_angles);
        end
        sample_ch.valid = 1'b0;

        wait (pending_angles.size() == 0);
        repeat (2 * LATENCY) @(posedge clk);
        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
`default_nettype wire
